/* design/sceq_pkg.sv */
// shared constants, types and helpers for the scancode event queue
`timescale 1ns / 1ps
package sceq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CODE_W      = 7;
  localparam int ENTRY_W     = CODE_W + 2;

  localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
  localparam int         DATA_PRESENT = 0;
  localparam int         RELEASE_BIT  = 7;
  localparam int         ENT_REL      = CODE_W;
  localparam int         ENT_EXT      = CODE_W + 1;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // controller to datapath
  typedef struct packed {
    logic scan;       // decode a scancode word
    logic pop_read;   // read oldest entry into the result register
    logic pop_empty;  // empty pop, result is all zero
  } sceq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
  } sceq_stat_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

endpackage

/* design/sceq_if.sv */
// valid/ready channel interfaces for input words and result words
`timescale 1ns / 1ps
interface sceq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] status_byte;
  logic [7:0] scan_byte;

  modport source(output valid, output kind, output status_byte, output scan_byte,
                 input ready);
  modport sink(input valid, input kind, input status_byte, input scan_byte,
               output ready);
endinterface

interface sceq_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [6:0] key_code;
  logic       is_release;
  logic       is_extended;

  modport source(output valid, output event_valid, output key_code,
                 output is_release, output is_extended, input ready);
  modport sink(input valid, input event_valid, input key_code,
               input is_release, input is_extended, output ready);
endinterface

/* design/sceq_ctrl.sv */
// controller state machine: takes one word, holds the result until taken
`timescale 1ns / 1ps
module sceq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sceq_pkg::sceq_stat_t stat,
  output sceq_pkg::sceq_cmd_t  cmd
);
  import sceq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_OUT  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.scan      = accept && (in_kind == KIND_SCAN);
    cmd.pop_read  = accept && (in_kind == KIND_POP) && !stat.empty;
    cmd.pop_empty = accept && (in_kind == KIND_POP) && stat.empty;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_POP)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/sceq_dp.sv */
// datapath: prefix flag, ring pointers, event memory and result register
`timescale 1ns / 1ps
module sceq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sceq_pkg::sceq_cmd_t  cmd,
  output sceq_pkg::sceq_stat_t stat,
  input  logic [7:0]           status_byte,
  input  logic [7:0]           scan_byte,
  output logic                 event_valid,
  output logic [6:0]           key_code,
  output logic                 is_release,
  output logic                 is_extended
);
  import sceq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  logic   prefix_r, prefix_nxt;
  ptr_t   wr_ptr_r, wr_ptr_nxt;
  ptr_t   rd_ptr_r, rd_ptr_nxt;
  logic   ev_valid_r, ev_valid_nxt;
  entry_t rdata_r;
  entry_t new_entry;
  logic   take, is_prefix, full, push;

  assign stat.empty = (wr_ptr_r == rd_ptr_r);
  assign full       = (ptr_inc(wr_ptr_r) == rd_ptr_r);
  assign take       = cmd.scan && status_byte[DATA_PRESENT];
  assign is_prefix  = (scan_byte == PREFIX_BYTE);
  assign push       = take && !is_prefix && !full;

  assign new_entry = {prefix_r, scan_byte[RELEASE_BIT], scan_byte[CODE_W-1:0]};

  always_comb begin
    prefix_nxt   = prefix_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    ev_valid_nxt = ev_valid_r;
    if (take) begin
      // prefix clears on any event byte, even one dropped on a full queue
      prefix_nxt = is_prefix;
    end
    if (push) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
    end
    if (cmd.pop_read) begin
      rd_ptr_nxt   = ptr_inc(rd_ptr_r);
      ev_valid_nxt = 1'b1;
    end
    if (cmd.pop_empty) begin
      ev_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r   <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      prefix_r   <= prefix_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_read) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  assign event_valid = ev_valid_r;
  assign key_code    = ev_valid_r ? rdata_r[CODE_W-1:0] : '0;
  assign is_release  = ev_valid_r && rdata_r[ENT_REL];
  assign is_extended = ev_valid_r && rdata_r[ENT_EXT];

endmodule

/* design/scancode_event_queue.sv */
// top level of the scancode event queue
`timescale 1ns / 1ps
// Set-1 keyboard scancode decoder in front of a ring queue of key events.
// A word with kind 0 carries a controller status byte and a scancode byte;
// the byte is used only when status bit 0 (data present) is set. Byte 0xE0
// arms the extended prefix; any other byte becomes an event (7-bit key code,
// release flag from bit 7, extended flag) and clears the prefix. The queue
// holds QUEUE_DEPTH-1 events; an event arriving while it is full is dropped.
// A word with kind 1 pops the oldest event and returns one result word, with
// event_valid low and all fields zero if the queue is empty. Scancode words
// give no result. Scancode words can be accepted back to back. A pop word
// is accepted, the event memory read lands in the result register on that
// edge, and the result is offered from the next cycle; no new word is taken
// until the result is consumed, so an output stall holds off further input.
// Queue memory contents need no clearing after reset; only the pointers, the
// prefix flag and the result valid flag are reset.
module scancode_event_queue (
  input logic       clk,
  input logic       rst_n,
  sceq_in_if.sink   in_ch,
  sceq_out_if.source out_ch
);
  import sceq_pkg::*;

  sceq_cmd_t  cmd;
  sceq_stat_t stat;

  // sequencing: accept, issue datapath command, hold result
  sceq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // decode, queue storage and result register
  sceq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .status_byte (in_ch.status_byte),
    .scan_byte   (in_ch.scan_byte),
    .event_valid (out_ch.event_valid),
    .key_code    (out_ch.key_code),
    .is_release  (out_ch.is_release),
    .is_extended (out_ch.is_extended)
  );

endmodule
